>>> hdl/cdd_pkg.sv
// shared types, constants and helpers for the capability descriptor decoder
package cdd_pkg;

    // permission mask geometry
    localparam int MASK_BITS  = 128;
    localparam int GROUP_SPAN = 24;
    localparam int NUM_ROWS   = (MASK_BITS + GROUP_SPAN - 1) / GROUP_SPAN;
    localparam int ROW_AW     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    // descriptor type prefixes (top 12 bits) and their match masks
    localparam logic [11:0] RANGE_MASK   = 12'hFFE;
    localparam logic [11:0] RANGE_CODE   = 12'hFF8;
    localparam logic [11:0] IRQ_MASK     = 12'hF00;
    localparam logic [11:0] IRQ_CODE     = 12'hE00;
    localparam logic [11:0] SVC_MASK     = 12'hF80;
    localparam logic [11:0] SVC_CODE     = 12'hF00;
    localparam logic [11:0] HANDLE_MASK  = 12'hFF0;
    localparam logic [11:0] HANDLE_CODE  = 12'hFE0;
    localparam logic [11:0] FLAGS_MASK   = 12'hFF8;
    localparam logic [11:0] FLAGS_CODE   = 12'hFF0;
    localparam logic [11:0] PAGE_CODE    = 12'hFFE;
    localparam logic [11:0] VERSION_MASK = 12'hFE0;
    localparam logic [11:0] VERSION_CODE = 12'hFC0;
    localparam logic [31:0] UNUSED_WORD  = 32'hFFFF_FFFF;

    // request codes
    localparam logic REQ_DECODE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // result classes
    typedef enum logic [3:0] {
        KIND_UNUSED    = 4'd0,
        KIND_IRQ       = 4'd1,
        KIND_SVC       = 4'd2,
        KIND_HANDLES   = 4'd3,
        KIND_FLAGS     = 4'd4,
        KIND_RANGE_HLD = 4'd5,
        KIND_RANGE     = 4'd6,
        KIND_PAGE      = 4'd7,
        KIND_VERSION   = 4'd8,
        KIND_UNHANDLED = 4'd9,
        KIND_READ      = 4'd10
    } kind_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] descriptor;
        logic        last_word;
        logic [2:0]  group_select;
    } cdd_in_t;

    typedef struct packed {
        kind_t       kind;
        logic        range_dropped;
        logic        map_valid;
        logic [31:0] map_base;
        logic [31:0] map_length;
        logic        map_writable;
        logic        map_extra_flag;
        logic [9:0]  handle_count;
        logic [15:0] misc_flags;
        logic [15:0] version_word;
        logic [23:0] group_bits;
    } cdd_out_t;

    // bits of a group that lie inside the mask
    function automatic logic [GROUP_SPAN-1:0] group_limit_mask(input logic [2:0] g);
        logic [GROUP_SPAN-1:0] m;
        m = '0;
        for (int k = 0; k < GROUP_SPAN; k++)
        begin
            m[k] = ((int'(g) * GROUP_SPAN + k) < MASK_BITS);
        end
        return m;
    endfunction

endpackage

>>> hdl/capability_descriptor_decoder_unit.sv
// capability descriptor decoder: classification, range pairing and syscall mask memory
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | cdd_in_t: request, descriptor word
//  out     | output    | out_valid/out_ready | cdd_out_t: class, mapping, regs
//
// one item is accepted every cycle while the output does not stall; its result
// passes the decode stage register (with the mask row read), then the buffer
// the mask is a row-per-group memory with per-bit write enables, so group writes
// need no read-back; a read follows a write to the same row with no interlock
// reset clears the row valid bits at once, no clearing pass; rows not yet written read zero
// in_ready comes from registers only; a stalled output fills the buffer, then stops input
module capability_descriptor_decoder_unit
    import cdd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cdd_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output cdd_out_t out_item
);

    // mask memory
    logic [GROUP_SPAN-1:0] mask_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]   row_valid_reg;
    logic [NUM_ROWS-1:0]   row_valid_next;
    logic [GROUP_SPAN-1:0] rd_data_reg;
    logic                  rd_hit_reg;
    logic [2:0]            rd_group_reg;

    // decode state
    logic        pending_valid_reg;
    logic        pending_valid_next;
    logic [20:0] pending_start_reg;
    logic [20:0] pending_start_next;
    logic [9:0]  handle_reg;
    logic [9:0]  handle_next;
    logic [15:0] flag_reg;
    logic [15:0] flag_next;
    logic [15:0] version_reg;
    logic [15:0] version_next;

    // stage register
    logic     stage_valid_reg;
    logic     stage_valid_next;
    cdd_out_t stage_reg;
    cdd_out_t stage_res;

    // buffer side
    logic     buf_ready;
    logic     advance;
    logic     in_fire;
    cdd_out_t stage_out;

    // write port
    logic                  mem_we;
    logic [ROW_AW-1:0]     mem_waddr;
    logic [GROUP_SPAN-1:0] mem_wdata;
    logic [GROUP_SPAN-1:0] mem_bit_en;
    logic [ROW_AW-1:0]     rd_addr;
    logic                  rd_in_range;

    assign advance  = stage_valid_reg && buf_ready;
    assign in_ready = !stage_valid_reg || buf_ready;
    assign in_fire  = in_valid && in_ready;

    // descriptor decode and next state
    always_comb
    begin
        logic [11:0]           dtype;
        logic [31:0]           d;
        logic [GROUP_SPAN-1:0] bits;
        logic [GROUP_SPAN-1:0] fill;
        logic [19:0]           diff;
        logic [2:0]            wgrp;

        d    = in_item.descriptor;
        dtype = d[31:20];
        bits = d[GROUP_SPAN-1:0];
        wgrp = d[26:24];
        diff = d[19:0] - pending_start_reg[19:0];

        // smear toward bit 0: every bit up to the highest set one
        fill = bits;
        fill = fill | (fill >> 1);
        fill = fill | (fill >> 2);
        fill = fill | (fill >> 4);
        fill = fill | (fill >> 8);
        fill = fill | (fill >> 16);

        pending_valid_next = pending_valid_reg;
        pending_start_next = pending_start_reg;
        handle_next        = handle_reg;
        flag_next          = flag_reg;
        version_next       = version_reg;
        row_valid_next     = row_valid_reg;
        mem_we             = 1'b0;
        mem_waddr          = wgrp[ROW_AW-1:0];
        mem_wdata          = bits;
        mem_bit_en         = fill;

        stage_res                = '0;
        stage_res.kind           = KIND_UNHANDLED;

        if (in_item.req_type == REQ_READ)
        begin
            stage_res.kind = KIND_READ;
        end
        else if ((dtype & RANGE_MASK) == RANGE_CODE)
        begin
            if (pending_valid_reg)
            begin
                stage_res.kind           = KIND_RANGE;
                stage_res.map_valid      = 1'b1;
                stage_res.map_base       = {pending_start_reg[19:0], 12'h000};
                stage_res.map_length     = {diff, 12'h000};
                stage_res.map_writable   = pending_start_reg[20];
                stage_res.map_extra_flag = d[20];
                pending_valid_next       = 1'b0;
                pending_start_next       = '0;
            end
            else if (in_item.last_word)
            begin
                stage_res.kind          = KIND_RANGE;
                stage_res.range_dropped = 1'b1;
            end
            else
            begin
                stage_res.kind     = KIND_RANGE_HLD;
                pending_valid_next = 1'b1;
                pending_start_next = d[20:0];
            end
        end
        else
        begin
            if (pending_valid_reg)
            begin
                stage_res.range_dropped = 1'b1;
                pending_valid_next      = 1'b0;
                pending_start_next      = '0;
            end
            if (d == UNUSED_WORD)
            begin
                stage_res.kind = KIND_UNUSED;
            end
            else if ((dtype & IRQ_MASK) == IRQ_CODE)
            begin
                stage_res.kind = KIND_IRQ;
            end
            else if ((dtype & SVC_MASK) == SVC_CODE)
            begin
                stage_res.kind = KIND_SVC;
                if ((bits != '0) && (int'(wgrp) < NUM_ROWS))
                begin
                    mem_we = 1'b1;
                    // first write of a row also clears the bits above the fill
                    if (!row_valid_reg[wgrp[ROW_AW-1:0]])
                    begin
                        mem_bit_en = '1;
                    end
                    row_valid_next[wgrp[ROW_AW-1:0]] = 1'b1;
                end
            end
            else if ((dtype & HANDLE_MASK) == HANDLE_CODE)
            begin
                stage_res.kind = KIND_HANDLES;
                handle_next    = d[9:0];
            end
            else if ((dtype & FLAGS_MASK) == FLAGS_CODE)
            begin
                stage_res.kind = KIND_FLAGS;
                flag_next      = d[15:0];
            end
            else if (dtype == PAGE_CODE)
            begin
                stage_res.kind         = KIND_PAGE;
                stage_res.map_valid    = 1'b1;
                stage_res.map_base     = {d[19:0], 12'h000};
                stage_res.map_length   = 32'h0000_1000;
                stage_res.map_writable = 1'b1;
            end
            else if ((dtype & VERSION_MASK) == VERSION_CODE)
            begin
                stage_res.kind = KIND_VERSION;
                version_next   = d[15:0];
            end
            else
            begin
                stage_res.kind = KIND_UNHANDLED;
            end
        end

        // end of list drops anything held
        if ((in_item.req_type == REQ_DECODE) && in_item.last_word)
        begin
            pending_valid_next = 1'b0;
            pending_start_next = '0;
        end

        stage_res.handle_count = handle_next;
        stage_res.misc_flags   = flag_next;
        stage_res.version_word = version_next;
    end

    // read address of the requested group
    assign rd_addr     = in_item.group_select[ROW_AW-1:0];
    assign rd_in_range = (int'(in_item.group_select) < NUM_ROWS);

    // stage occupancy
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // control and decode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            pending_valid_reg <= 1'b0;
            pending_start_reg <= '0;
            handle_reg        <= '0;
            flag_reg          <= '0;
            version_reg       <= '0;
            row_valid_reg     <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (in_fire)
            begin
                pending_valid_reg <= pending_valid_next;
                pending_start_reg <= pending_start_next;
                handle_reg        <= handle_next;
                flag_reg          <= flag_next;
                version_reg       <= version_next;
                row_valid_reg     <= row_valid_next;
            end
        end
    end

    // mask memory write with per-bit enables
    always_ff @(posedge clk)
    begin
        if (in_fire && mem_we)
        begin
            for (int k = 0; k < GROUP_SPAN; k++)
            begin
                if (mem_bit_en[k])
                begin
                    mask_mem[mem_waddr][k] <= mem_wdata[k];
                end
            end
        end
    end

    // mask memory read and stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg  <= mask_mem[rd_addr];
            rd_hit_reg   <= rd_in_range && row_valid_reg[rd_addr];
            rd_group_reg <= in_item.group_select;
            stage_reg    <= stage_res;
        end
    end

    // merge the read row into the result
    always_comb
    begin
        stage_out = stage_reg;
        if ((stage_reg.kind == KIND_READ) && rd_hit_reg)
        begin
            stage_out.group_bits = rd_data_reg & group_limit_mask(rd_group_reg);
        end
        else
        begin
            stage_out.group_bits = '0;
        end
    end

    cdd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid_reg),
        .in_ready  (buf_ready),
        .in_item   (stage_out),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

>>> hdl/cdd_skid.sv
// two-entry output buffer with a registered ready toward the decoder
module cdd_skid
    import cdd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cdd_out_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output cdd_out_t out_item
);

    logic     main_valid_reg;
    logic     main_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    cdd_out_t main_reg;
    cdd_out_t skid_reg;
    logic     in_fire;
    logic     main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign main_free = out_ready || !main_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    // occupancy
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_free)
        begin
            main_valid_next = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_item;
        end
        else if (in_fire)
        begin
            skid_reg <= in_item;
        end
    end

endmodule

>>> tb/capability_descriptor_decoder_unit_tb.sv
// self-checking testbench for the capability descriptor decoder unit
module capability_descriptor_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // descriptor families used to build well-formed lists
    typedef enum int {
        W_UNUSED,
        W_IRQ,
        W_SVC,
        W_HANDLES,
        W_FLAGS,
        W_PAGE,
        W_VERSION,
        W_RANGE,
        W_OTHER
    } word_class_t;

    // decoder state mirror and queue of expected results
    class descriptor_scoreboard;
        bit          mask_bits [MASK_BITS];
        bit          range_held;
        logic [20:0] held_start;
        logic [9:0]  handles;
        logic [15:0] flags;
        logic [15:0] version;
        cdd_out_t    expected_q[$];
        int          errors;

        function new();
            foreach (mask_bits[i])
            begin
                mask_bits[i] = 1'b0;
            end
            range_held = 1'b0;
            held_start = '0;
            handles    = '0;
            flags      = '0;
            version    = '0;
            errors     = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // work out the result of one accepted item and advance the state
        function cdd_out_t decode(cdd_in_t it);
            cdd_out_t    r;
            logic [11:0] prefix;
            logic [31:0] d;
            logic [31:0] start_addr;
            logic [31:0] end_addr;
            logic [23:0] bits;
            int          idx;
            r = '0;
            d = it.descriptor;
            prefix = d[31:20];
            if (it.req_type == REQ_READ)
            begin
                r.kind = KIND_READ;
                for (int k = 0; k < GROUP_SPAN; k++)
                begin
                    idx = int'(it.group_select) * GROUP_SPAN + k;
                    if (idx < MASK_BITS && mask_bits[idx])
                    begin
                        r.group_bits[k] = 1'b1;
                    end
                end
            end
            else if ((prefix & RANGE_MASK) == RANGE_CODE)
            begin
                if (range_held)
                begin
                    // second word closes the pair whatever its own bits
                    start_addr = {held_start[19:0], 12'h000};
                    end_addr   = {d[19:0], 12'h000};
                    r.kind           = KIND_RANGE;
                    r.map_valid      = 1'b1;
                    r.map_base       = start_addr;
                    r.map_length     = end_addr - start_addr;
                    r.map_writable   = held_start[20];
                    r.map_extra_flag = d[20];
                    range_held = 1'b0;
                    held_start = '0;
                end
                else if (it.last_word)
                begin
                    // start on the final word has no partner
                    r.kind          = KIND_RANGE;
                    r.range_dropped = 1'b1;
                end
                else
                begin
                    r.kind     = KIND_RANGE_HLD;
                    range_held = 1'b1;
                    held_start = d[20:0];
                end
            end
            else
            begin
                // a held start not followed by a range word is discarded
                if (range_held)
                begin
                    r.range_dropped = 1'b1;
                    range_held = 1'b0;
                    held_start = '0;
                end
                if (d == UNUSED_WORD)
                begin
                    r.kind = KIND_UNUSED;
                end
                else if ((prefix & IRQ_MASK) == IRQ_CODE)
                begin
                    r.kind = KIND_IRQ;
                end
                else if ((prefix & SVC_MASK) == SVC_CODE)
                begin
                    // copy low bits first up to the highest set bit
                    r.kind = KIND_SVC;
                    idx  = int'(d[26:24]) * GROUP_SPAN;
                    bits = d[23:0];
                    while (bits != 0 && idx < MASK_BITS)
                    begin
                        mask_bits[idx] = bits[0];
                        idx++;
                        bits = bits >> 1;
                    end
                end
                else if ((prefix & HANDLE_MASK) == HANDLE_CODE)
                begin
                    r.kind  = KIND_HANDLES;
                    handles = d[9:0];
                end
                else if ((prefix & FLAGS_MASK) == FLAGS_CODE)
                begin
                    r.kind = KIND_FLAGS;
                    flags  = d[15:0];
                end
                else if (prefix == PAGE_CODE)
                begin
                    r.kind         = KIND_PAGE;
                    r.map_valid    = 1'b1;
                    r.map_base     = {d[19:0], 12'h000};
                    r.map_length   = 32'd4096;
                    r.map_writable = 1'b1;
                end
                else if ((prefix & VERSION_MASK) == VERSION_CODE)
                begin
                    r.kind  = KIND_VERSION;
                    version = d[15:0];
                end
                else
                begin
                    r.kind = KIND_UNHANDLED;
                end
            end
            // end of list clears any held start
            if (it.req_type == REQ_DECODE && it.last_word)
            begin
                range_held = 1'b0;
                held_start = '0;
            end
            r.handle_count = handles;
            r.misc_flags   = flags;
            r.version_word = version;
            return r;
        endfunction

        function void note_input(cdd_in_t it);
            expected_q.insert(expected_q.size(), decode(it));
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s expected %0h actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(cdd_out_t act);
            cdd_out_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            check_field("kind", 32'(exp_r.kind), 32'(act.kind));
            check_field("range_dropped", 32'(exp_r.range_dropped), 32'(act.range_dropped));
            check_field("map_valid", 32'(exp_r.map_valid), 32'(act.map_valid));
            check_field("map_base", exp_r.map_base, act.map_base);
            check_field("map_length", exp_r.map_length, act.map_length);
            check_field("map_writable", 32'(exp_r.map_writable), 32'(act.map_writable));
            check_field("map_extra_flag", 32'(exp_r.map_extra_flag),
                        32'(act.map_extra_flag));
            check_field("handle_count", 32'(exp_r.handle_count), 32'(act.handle_count));
            check_field("misc_flags", 32'(exp_r.misc_flags), 32'(act.misc_flags));
            check_field("version_word", 32'(exp_r.version_word), 32'(act.version_word));
            check_field("group_bits", 32'(exp_r.group_bits), 32'(act.group_bits));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    cdd_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    cdd_out_t out_item;

    int send_idle;
    int recv_idle;
    int cycle_count;

    descriptor_scoreboard sb = new();

    capability_descriptor_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted items, then pick next ready
    initial
    begin
        out_ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_item);
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // one item with random group select
    function automatic cdd_in_t make_item(logic req, logic [31:0] word, logic last);
        cdd_in_t it;
        it.req_type     = req;
        it.descriptor   = word;
        it.last_word    = last;
        it.group_select = 3'($urandom_range(7));
        return it;
    endfunction

    // random descriptor of the given family
    function automatic logic [31:0] make_word(word_class_t c);
        logic [31:0] w;
        int          width;
        w = $urandom;
        case (c)
            W_UNUSED:  w = UNUSED_WORD;
            W_IRQ:     w[31:28] = 4'hE;
            W_SVC:
            begin
                w[31:27] = 5'b11110;
                width = $urandom_range(0, 24);
                if ($urandom_range(1) == 0)
                begin
                    w[23:0] = w[23:0] & ((24'h1 << width) - 24'h1);
                end
            end
            W_HANDLES: w[31:24] = 8'hFE;
            W_FLAGS:   w[31:23] = 9'h1FE;
            W_PAGE:    w[31:20] = PAGE_CODE;
            W_VERSION: w[31:25] = 7'b1111110;
            W_RANGE:   w[31:21] = 11'b11111111100;
            default:   w[31:28] = 4'($urandom_range(0, 13));
        endcase
        return w;
    endfunction

    // present one item, with a random gap before it, and wait for acceptance
    task automatic send_item(input cdd_in_t it);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_input(it);
    endtask

    task automatic run_directed();
        // unhandled, unused, interrupt lists
        send_item(make_item(REQ_DECODE, 32'h0000_0000, 1'b0));
        send_item(make_item(REQ_DECODE, UNUSED_WORD, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hE000_0000, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hEFFF_FFFF, 1'b0));
        // syscall groups: full, sparse, straddling and beyond the mask, empty
        send_item(make_item(REQ_DECODE, 32'hF0FF_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hF180_0001, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hF5FF_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hF7FF_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hF000_0000, 1'b0));
        for (int g = 0; g < 8; g++)
        begin
            send_item('{REQ_READ, 32'hFFFF_FFFF, 1'b1, 3'(g)});
        end
        // register latches and single pages
        send_item(make_item(REQ_DECODE, 32'hFE00_03FF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hFF00_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hFC00_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hFFEF_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hFFE0_0000, 1'b0));
        // range pair with wrapping length
        send_item(make_item(REQ_DECODE, 32'hFF9F_FFFF, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hFF80_0000, 1'b0));
        // held start survives a read, then is dropped by a non-range word
        send_item(make_item(REQ_DECODE, 32'hFF81_2345, 1'b0));
        send_item(make_item(REQ_READ, 32'h0000_0000, 1'b0));
        send_item(make_item(REQ_DECODE, 32'hF000_0001, 1'b0));
        // range start on the final word
        send_item(make_item(REQ_DECODE, 32'hFF9A_BCDE, 1'b1));
    endtask

    // lists of well-formed descriptors mixed with reads and noise
    task automatic run_random(input int target);
        cdd_in_t     list_q[$];
        int          sent;
        int          len;
        int          roll;
        word_class_t c;
        sent = 0;
        while (sent < target)
        begin
            list_q.delete();
            len = $urandom_range(1, 10);
            for (int p = 0; p < len; p++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    list_q.insert(list_q.size(),
                                  make_item(REQ_READ, $urandom, 1'($urandom_range(1))));
                end
                else if (roll < 16)
                begin
                    list_q.insert(list_q.size(),
                                  make_item(REQ_DECODE, $urandom, 1'($urandom_range(1))));
                end
                else
                begin
                    c = word_class_t'($urandom_range(0, W_OTHER));
                    list_q.insert(list_q.size(), make_item(REQ_DECODE, make_word(c), 1'b0));
                    // mostly follow a range start with its end word
                    if (c == W_RANGE && $urandom_range(99) < 80)
                    begin
                        if ($urandom_range(99) < 15)
                        begin
                            list_q.insert(list_q.size(), make_item(REQ_READ, $urandom, 1'b0));
                        end
                        list_q.insert(list_q.size(),
                                      make_item(REQ_DECODE, make_word(W_RANGE), 1'b0));
                    end
                end
            end
            // mark the end of most lists on their final descriptor
            if ($urandom_range(99) < 90)
            begin
                for (int i = list_q.size() - 1; i >= 0; i--)
                begin
                    if (list_q[i].req_type == REQ_DECODE)
                    begin
                        list_q[i].last_word = 1'b1;
                        break;
                    end
                end
            end
            foreach (list_q[i])
            begin
                send_item(list_q[i]);
            end
            sent += list_q.size();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        send_idle = 21;
        recv_idle = 77;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(360);

        send_idle = 77;
        recv_idle = 21;
        run_random(360);

        send_idle = 0;
        recv_idle = 0;
        run_random(360);

        in_valid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
